// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the decoder.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is asserted.
`define URLPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("urlpd assertion failed");

// Condition that must never be seen on a rising edge outside reset.
`define URLPD_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("urlpd forbidden condition seen");

`endif

// File: hdl/urlpd_pkg.sv
// Types, constants and helper functions of the URL percent decoder.
// No dependencies; imported by the decode step, the top level and the checker.
`default_nettype none

package urlpd_pkg;

  // Register widths and reset values
  localparam int unsigned MaxInW  = 14;
  localparam int unsigned MaxOutW = 13;
  localparam logic [MaxInW-1:0]  MAX_IN_RESET  = 14'd12288;
  localparam logic [MaxOutW-1:0] MAX_OUT_RESET = 13'd4096;
  localparam logic [MaxInW-1:0]  IN_CNT_MAX    = 14'd16383;
  localparam logic [MaxOutW-1:0] OUT_CNT_MAX   = 13'd8191;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_IN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_OUT = 2'd1;

  // Character codes
  localparam logic [7:0] CHR_PLUS    = 8'h2b;
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_DEL     = 8'h7f;

  // Escape tracking: outside, awaiting high digit, awaiting low digit
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

  // Per-string decoding state
  typedef struct packed {
    phase_e             phase;
    logic [3:0]         nibble;
    logic [MaxInW-1:0]  in_cnt;
    logic [MaxOutW-1:0] out_cnt;
    logic               failed;
  } str_t;

  localparam str_t STR_RESET = '{
    phase:   PH_IDLE,
    nibble:  4'd0,
    in_cnt:  '0,
    out_cnt: '0,
    failed:  1'b0
  };

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       error;
    logic       done;
  } res_t;

  // Hex digit decode: bit 4 set when the character is a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Control characters and DEL are rejected
  function automatic logic is_forbidden(input logic [7:0] b);
    return (b < CHR_SPACE) || (b == CHR_DEL);
  endfunction

endpackage

`default_nettype wire

// File: hdl/url_percent_decoder_core.sv
// URL form decoder, top level: input register, decode step, output register and skid.
// Depends on urlpd_pkg and urlpd_step.
`default_nettype none
//
// Usage
//   Input channel: in_valid_i / in_stall_o carry one encoded byte (in_byte_i)
//   and its end-of-string flag (last_i); a word is taken on an edge with
//   in_valid_i high and in_stall_o low.
//   Result channel: res_valid_o / res_stall_i carry exactly one result word
//   per input word: out_byte_o, out_valid_o, error_o and done_res_o.
//   Result path: a taken word is held in the input register, then the decode
//   step writes its result into the output register and res_valid_o rises; a
//   full skid register holds the word in the input register until it drains.
//   Throughput: one word per cycle while no stall holds the result channel;
//   the decode step is a single short update of the string state between the
//   input and output registers. Stall: when res_stall_i holds a result, one
//   more result parks in the skid register; in_stall_o rises once the skid is
//   full and a further word waits in the input register. After the stall clears
//   the skid drains first, and the pipeline moves again once it is empty.
//   Reset: clears all pipeline valids and the string state, and loads the
//   limits with 12288 input and 4096 output bytes.
//   Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i; the
//   user must write only while the block is idle, which the block does not enforce.
//
module url_percent_decoder_core
  import urlpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MaxInW-1:0]  cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               last_i,
  // result channel
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               out_valid_o,
  output logic               error_o,
  output logic               done_res_o
);

  logic [MaxInW-1:0]  max_in_q;
  logic [MaxOutW-1:0] max_out_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  str_t st_q;
  str_t st_d;
  res_t res_d;

  logic o_valid_q;
  res_t o_res_q;
  logic sk_valid_q;
  res_t sk_res_q;

  logic in_take;
  logic s1_go;
  logic res_take;
  logic o_free;

  assign res_take = o_valid_q && !res_stall_i;
  assign s1_go    = s1_valid_q && !sk_valid_q;
  assign o_free   = !o_valid_q || res_take;
  assign in_stall_o = s1_valid_q && sk_valid_q;
  assign in_take  = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_in_q  <= MAX_IN_RESET;
      max_out_q <= MAX_OUT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MAX_IN) begin
        max_in_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_MAX_OUT) begin
        max_out_q <= cfg_data_i[MaxOutW-1:0];
      end
    end
  end

  // Input register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= last_i;
    end
  end

  urlpd_step u_step (
    .st_i      (st_q),
    .in_byte_i (s1_byte_q),
    .last_i    (s1_last_q),
    .max_in_i  (max_in_q),
    .max_out_i (max_out_q),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  // String state advances with each decoded word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STR_RESET;
    end else if (s1_go) begin
      st_q <= st_d;
    end
  end

  // Output and skid valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else begin
      if (sk_valid_q) begin
        if (res_take) begin
          sk_valid_q <= 1'b0;
        end
      end else if (s1_go) begin
        if (o_free) begin
          o_valid_q <= 1'b1;
        end else begin
          sk_valid_q <= 1'b1;
        end
      end else if (res_take) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (res_take) begin
        o_res_q <= sk_res_q;
      end
    end else if (s1_go) begin
      if (o_free) begin
        o_res_q <= res_d;
      end else begin
        sk_res_q <= res_d;
      end
    end
  end

  assign res_valid_o = o_valid_q;
  assign out_byte_o  = o_res_q.out_byte;
  assign out_valid_o = o_res_q.out_valid;
  assign error_o     = o_res_q.error;
  assign done_res_o  = o_res_q.done;

endmodule

`default_nettype wire

// File: hdl/urlpd_step.sv
// Combinational decode step: one encoded byte against the string state.
// Depends on urlpd_pkg for the state and result types and helpers.
`default_nettype none

module urlpd_step
  import urlpd_pkg::*;
(
  input  str_t               st_i,
  input  logic [7:0]         in_byte_i,
  input  logic               last_i,
  input  logic [MaxInW-1:0]  max_in_i,
  input  logic [MaxOutW-1:0] max_out_i,
  output str_t               st_o,
  output res_t               res_o
);

  logic [4:0] hex;
  logic       fail;
  logic       emit;
  logic [7:0] value;
  str_t       nxt;

  assign hex = hex_decode(in_byte_i);

  // Next state and result for this byte
  always_comb begin
    nxt   = st_i;
    fail  = st_i.failed;
    emit  = 1'b0;
    value = 8'd0;
    if (!st_i.failed) begin
      if (st_i.in_cnt >= max_in_i) begin
        fail = 1'b1;
      end else begin
        if (st_i.in_cnt != IN_CNT_MAX) begin
          nxt.in_cnt = st_i.in_cnt + 14'd1;
        end
        case (st_i.phase)
          PH_HIGH: begin
            if (!hex[4]) begin
              fail = 1'b1;
            end else begin
              nxt.nibble = hex[3:0];
              nxt.phase  = PH_LOW;
            end
          end
          PH_LOW: begin
            nxt.phase = PH_IDLE;
            if (!hex[4]) begin
              fail = 1'b1;
            end else begin
              value = {st_i.nibble, hex[3:0]};
              if (is_forbidden(value)) begin
                fail = 1'b1;
              end else begin
                emit = 1'b1;
              end
            end
          end
          default: begin
            nxt.phase = PH_IDLE;
            if (in_byte_i == CHR_PLUS) begin
              value = CHR_SPACE;
              emit  = 1'b1;
            end else if (in_byte_i == CHR_PERCENT) begin
              nxt.phase = PH_HIGH;
            end else if (is_forbidden(in_byte_i)) begin
              fail = 1'b1;
            end else begin
              value = in_byte_i;
              emit  = 1'b1;
            end
          end
        endcase
        // Output limit check
        if (emit) begin
          if (st_i.out_cnt >= max_out_i) begin
            fail = 1'b1;
            emit = 1'b0;
          end else if (st_i.out_cnt != OUT_CNT_MAX) begin
            nxt.out_cnt = st_i.out_cnt + 13'd1;
          end
        end
      end
      // String ending inside an escape
      if (last_i && !fail && (nxt.phase != PH_IDLE)) begin
        fail = 1'b1;
      end
    end
    nxt.failed = fail;
    if (last_i) begin
      nxt = STR_RESET;
    end
  end

  assign st_o            = nxt;
  assign res_o.out_byte  = emit ? value : 8'd0;
  assign res_o.out_valid = emit;
  assign res_o.error     = fail;
  assign res_o.done      = last_i;

endmodule

`default_nettype wire

// File: hdl/urlpd_checker.sv
// Port-level checker for the URL decoder, bound to the top level.
// Depends on urlpd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module urlpd_checker
  import urlpd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       last_i,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_valid_o,
  input logic       error_o,
  input logic       done_res_o
);

  logic        in_held;
  logic        res_held;
  logic        emitted;
  logic [8:0]  in_word;
  logic [10:0] res_word;

  assign in_held  = in_valid_i && in_stall_o;
  assign res_held = res_valid_o && res_stall_i;
  assign emitted  = res_valid_o && out_valid_o;
  assign in_word  = {in_byte_i, last_i};
  assign res_word = {out_byte_o, out_valid_o, error_o, done_res_o};

  // A held input word must stay put
  `URLPD_ASSERT(a_in_hold, clk_i, rst_ni, in_held |=> in_valid_i && $stable(in_word))

  // A held result word must stay put
  `URLPD_ASSERT(a_res_hold, clk_i, rst_ni, res_held |=> res_valid_o && $stable(res_word))

  // Input back-pressure only when a full result is waiting
  `URLPD_ASSERT(a_stall_needs_res, clk_i, rst_ni, in_stall_o |-> res_valid_o)

  // An emitted byte never comes with an error and is never a control code
  `URLPD_ASSERT(a_emit_clean, clk_i, rst_ni, emitted |-> !error_o && !is_forbidden(out_byte_o))

  // No decoded byte means a zero byte field
  `URLPD_NEVER(a_idle_byte_zero, clk_i, rst_ni, res_valid_o && !out_valid_o && out_byte_o != 8'd0)

endmodule

bind url_percent_decoder_core urlpd_checker u_urlpd_checker (.*);

`default_nettype wire

// File: tb/tb_url_percent_decoder_core.sv
// Self-checking testbench for url_percent_decoder_core: directed and random strings,
// checked word by word against a decode predictor. Depends on urlpd_pkg and the RTL.
`timescale 1ns / 100ps

module tb_url_percent_decoder_core;
  import urlpd_pkg::*;

  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  // Indexes the block has no register behind
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_word_t;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [MaxInW-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic [7:0]         in_byte = 8'h00;
  logic               in_last = 1'b0;
  logic               res_stall = 1'b0;
  logic               in_stall_o;
  logic               res_valid_o;
  logic [7:0]         out_byte_o;
  logic               out_valid_o;
  logic               error_o;
  logic               done_res_o;

  // Encoded words waiting to be offered, and decoded words still to come back
  enc_word_t enc_q[$];
  res_t      decoded_q[$];

  int unsigned queued_n = 0;
  int unsigned taken_n = 0;
  int unsigned phase_n = 0;
  int unsigned bad_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned stuck_cnt = 0;
  logic        in_taken = 1'b0;

  // Predictor copy of the limits and of the per-string state
  logic [MaxInW-1:0]  lim_in = MAX_IN_RESET;
  logic [MaxOutW-1:0] lim_out = MAX_OUT_RESET;
  phase_e             esc_st = PH_IDLE;
  logic [3:0]         hi_dig = 4'h0;
  logic [MaxInW-1:0]  in_seen = '0;
  logic [MaxOutW-1:0] out_made = '0;
  logic               bad_str = 1'b0;

  url_percent_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte),
    .last_i      (in_last),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .error_o     (error_o),
    .done_res_o  (done_res_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Hex digit value; bit 4 marks a legal digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else begin
      return 5'h00;
    end
    return {1'b1, d[3:0]};
  endfunction

  function automatic logic unprintable(input logic [7:0] v);
    return (v < CHR_SPACE) || (v == CHR_DEL);
  endfunction

  // One decode step on the predictor state; gives the word the block must return
  function automatic res_t decode_byte(input logic [7:0] b, input logic lst);
    res_t       r;
    logic [4:0] dv;
    logic [7:0] val;
    logic       emit;
    val  = 8'h00;
    emit = 1'b0;
    if (!bad_str) begin
      if (in_seen >= lim_in) begin
        bad_str = 1'b1;
      end else begin
        if (in_seen < IN_CNT_MAX) in_seen = in_seen + 14'd1;
        case (esc_st)
          PH_HIGH: begin
            dv = hex_val(b);
            if (!dv[4]) begin
              bad_str = 1'b1;
            end else begin
              hi_dig = dv[3:0];
              esc_st = PH_LOW;
            end
          end
          PH_LOW: begin
            dv = hex_val(b);
            esc_st = PH_IDLE;
            if (!dv[4]) begin
              bad_str = 1'b1;
            end else begin
              val = {hi_dig, dv[3:0]};
              if (unprintable(val)) bad_str = 1'b1;
              else emit = 1'b1;
            end
          end
          default: begin
            esc_st = PH_IDLE;
            if (b == CHR_PLUS) begin
              val  = CHR_SPACE;
              emit = 1'b1;
            end else if (b == CHR_PERCENT) begin
              esc_st = PH_HIGH;
            end else if (unprintable(b)) begin
              bad_str = 1'b1;
            end else begin
              val  = b;
              emit = 1'b1;
            end
          end
        endcase
        // output limit: the byte over it is dropped and fails the string
        if (emit) begin
          if (out_made >= lim_out) begin
            bad_str = 1'b1;
            emit    = 1'b0;
          end else if (out_made < OUT_CNT_MAX) begin
            out_made = out_made + 13'd1;
          end
        end
      end
      if (lst && !bad_str && esc_st != PH_IDLE) bad_str = 1'b1;
    end
    r.out_byte  = emit ? val : 8'h00;
    r.out_valid = emit;
    r.error     = bad_str;
    r.done      = lst;
    if (lst) begin
      esc_st   = PH_IDLE;
      hi_dig   = 4'h0;
      in_seen  = '0;
      out_made = '0;
      bad_str  = 1'b0;
    end
    return r;
  endfunction

  // Result check first, then prediction for the word taken on this edge
  always @(posedge clk_i) begin : mon_p
    res_t want;
    if (rst_n && res_valid_o && !res_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %02h valid %b error %b done %b",
                 $time, out_byte_o, out_valid_o, error_o, done_res_o);
        bad_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, out_byte_o);
          bad_cnt++;
        end
        if (out_valid_o !== want.out_valid) begin
          $display("%0t: out_valid expected %b actual %b", $time, want.out_valid, out_valid_o);
          bad_cnt++;
        end
        if (error_o !== want.error) begin
          $display("%0t: error expected %b actual %b", $time, want.error, error_o);
          bad_cnt++;
        end
        if (done_res_o !== want.done) begin
          $display("%0t: done_res expected %b actual %b", $time, want.done, done_res_o);
          bad_cnt++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall_o) begin
      decoded_q = {decoded_q, decode_byte(in_byte, in_last)};
      taken_n++;
    end
    in_taken <= rst_n && in_valid && !in_stall_o;
  end

  // Sender: a word is held until taken, then the next one or a gap
  always @(negedge clk_i) begin : drv_p
    enc_word_t w;
    if (!in_valid || in_taken) begin
      if (enc_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = enc_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= w.data;
        in_last  <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      res_stall <= 1'b1;
      hold_len--;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (res_valid_o && !res_stall)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= StuckLimit) begin
      $display("url_percent_decoder_core: mismatch");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  task automatic queue_word(input logic [7:0] data, input logic lst);
    enc_word_t w;
    w.data = data;
    w.last = lst;
    enc_q = {enc_q, w};
    queued_n++;
    phase_n++;
  endtask

  task automatic queue_text(input string t);
    for (int i = 0; i < t.len(); i++) queue_word(t[i], i == t.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return {4'h0, n} + 8'h30;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  // Mostly well-formed strings with random content; some noise and broken escapes
  task automatic queue_random_string();
    logic [7:0]  s[$];
    logic [7:0]  v;
    int unsigned n;
    int unsigned r;
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 14);
    while (s.size() < n) begin
      r = $urandom_range(99);
      if (r < 45) begin
        v = 8'($urandom_range(8'h20, 8'h7e));
        if (v == CHR_PERCENT) v = CHR_PLUS;
        s = {s, v};
      end else if (r < 55) begin
        s = {s, CHR_PLUS};
      end else if (r < 85) begin
        v = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7e));
        s = {s, CHR_PERCENT};
        s = {s, hex_char(v[7:4])};
        s = {s, hex_char(v[3:0])};
      end else if (r < 93) begin
        s = {s, CHR_PERCENT};
        if ($urandom_range(1)) s = {s, hex_char(4'($urandom))};
        s = {s, 8'($urandom)};
      end else begin
        s = {s, 8'($urandom)};
      end
    end
    // now and then leave an escape open at the end
    if ($urandom_range(24) == 0) begin
      s = {s, CHR_PERCENT};
      if ($urandom_range(1)) s = {s, hex_char(4'($urandom))};
    end
    foreach (s[i]) queue_word(s[i], i == s.size() - 1);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MaxInW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_MAX_IN:  lim_in = data;
      CFG_MAX_OUT: lim_out = data[MaxOutW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Idle once every queued word is taken and every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (taken_n != queued_n || decoded_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed strings on the reset limits
    queue_word(8'h00, 1'b0);
    queue_word("x", 1'b1);
    queue_word(8'hff, 1'b1);
    queue_text("+%9A%Fe");
    queue_text("%0f");
    queue_text("%g");
    queue_text("%aZ");
    queue_text("%");
    queue_text("%5");
    queue_word(CHR_DEL, 1'b0);
    queue_word("a", 1'b1);
    wait_drained();

    // Input and output limits crossed within a string
    write_reg(CFG_MAX_IN, 14'd6);
    write_reg(CFG_MAX_OUT, 14'd3);
    queue_text("abcd");
    queue_text("%41%42z");
    queue_text("ab");
    wait_drained();

    // Random phases, each with its own limits and idling pattern
    for (int k = 0; k < 8; k++) begin
      phase_n = 0;
      case (k)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_reg(CFG_MAX_IN, 14'd16383);
          write_reg(CFG_MAX_OUT, 14'h3fff);
          hold_len = HoldCycles;
        end
        1: begin
          send_idle_pct = 67; recv_stall_pct = 0;
          write_reg(CFG_MAX_IN, 14'd12);
          write_reg(CFG_MAX_OUT, 14'd8);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 67;
          write_reg(CFG_MAX_IN, 14'($urandom_range(1, 40)));
          write_reg(CFG_MAX_OUT, 14'($urandom_range(1, 30)));
          write_reg(CFG_SPARE_A, 14'($urandom));
        end
        3: begin
          send_idle_pct = 11; recv_stall_pct = 11;
          write_reg(CFG_MAX_IN, 14'd1);
          write_reg(CFG_MAX_OUT, 14'd1);
        end
        4: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_reg(CFG_MAX_IN, 14'($urandom_range(1, 16383)));
          write_reg(CFG_MAX_OUT, 14'($urandom));
        end
        5: begin
          send_idle_pct = 67; recv_stall_pct = 0;
          write_reg(CFG_MAX_IN, 14'd0);
          write_reg(CFG_MAX_OUT, 14'd0);
        end
        6: begin
          send_idle_pct = 0;  recv_stall_pct = 67;
          write_reg(CFG_MAX_IN, 14'd20);
          write_reg(CFG_MAX_OUT, 14'($urandom_range(8192, 16383)));
        end
        default: begin
          send_idle_pct = 11; recv_stall_pct = 11;
          write_reg(CFG_MAX_IN, 14'($urandom_range(2, 24)));
          write_reg(CFG_MAX_OUT, 14'($urandom_range(1, 16)));
          write_reg(CFG_SPARE_B, 14'($urandom));
        end
      endcase
      while (phase_n < ((k == 5) ? 30 : 130)) queue_random_string();
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (bad_cnt == 0 && decoded_q.size() == 0) begin
      $display("url_percent_decoder_core: match");
    end else begin
      $display("url_percent_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
